@@ rtl/core/line_ring_log_buffer_macros.svh @@
// Assertion macros for the line ring log buffer.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef LINE_RING_LOG_BUFFER_MACROS_SVH
`define LINE_RING_LOG_BUFFER_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked while out of reset
`define LRLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked at every edge, reset included
`define LRLB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRLB_ASSERT(lbl, prop, msg)
`define LRLB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/core/lrlb_pkg.sv @@
// Shared types and constants for the line ring log buffer.
// No dependencies.
`default_nettype none
package lrlb_pkg;

  // default geometry
  localparam int DEF_LINES = 256;
  localparam int DEF_COLS  = 128;

  // special bytes
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] char_in;
    logic [7:0] line_index;
    logic [6:0] column;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       line_valid;
    logic [8:0] line_count;
  } out_word_t;

endpackage
`default_nettype wire

@@ rtl/core/lrlb_in_if.sv @@
// Input channel of the line ring log buffer: valid/ready plus one command word.
// Depends on lrlb_pkg.
`default_nettype none
interface lrlb_in_if;
  logic              valid;
  logic              ready;
  lrlb_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lrlb_out_if.sv @@
// Result channel of the line ring log buffer: valid/ready plus one result word.
// Depends on lrlb_pkg.
`default_nettype none
interface lrlb_out_if;
  logic               valid;
  logic               ready;
  lrlb_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/line_ring_log_buffer.sv @@
// Line ring log buffer: usage
//   in_bus takes one command word per handshake. A put word appends char_in to
//   the line being written (CR dropped, LF closes the line, a full line of
//   COLS-1 bytes closes by itself). A read word returns the byte at line_index
//   (0 = oldest visible line) and column, or 0 past the line end.
//   out_bus gives exactly one result word per command word, in order; every
//   result carries the visible line count after the command.
//   A put result is valid the cycle after acceptance; a read result is valid
//   the cycle after the text and length memories return data.
//   Throughput: one put per cycle while out_bus takes results; a read holds
//   in_bus.ready low until its result is in the output register, as the
//   registered text memory read is followed by the length compare.
//   Reset (synchronous, rst_n low) empties the ring: no lines, head at slot 0.
//   The memories are not cleared; reads are gated by the stored lengths.
//   When out_bus stalls, one finished word waits in the output register and
//   in_bus.ready drops until it is taken.
// Depends on lrlb_pkg, lrlb_in_if, lrlb_out_if, line_ring_log_buffer_macros.svh.
`default_nettype none
`include "line_ring_log_buffer_macros.svh"
module line_ring_log_buffer #(
  parameter int LINES = lrlb_pkg::DEF_LINES,
  parameter int COLS  = lrlb_pkg::DEF_COLS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lrlb_in_if.sink   in_bus,
  lrlb_out_if.source out_bus
);
  import lrlb_pkg::*;

  localparam int SLOT_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int SW1    = SLOT_W + 1;
  localparam int CNT_W  = $clog2(LINES + 1);
  localparam int COL_W  = $clog2(COLS);
  localparam int CMP_W  = (COL_W > 7) ? COL_W : 7;
  localparam int IDX_W  = (CNT_W > 8) ? CNT_W : 8;
  localparam int TXT_D  = LINES * (2 ** COL_W);

  localparam logic [SW1-1:0]   LINES_S = SW1'(LINES);
  localparam logic [CNT_W-1:0] LINES_C = CNT_W'(LINES);
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLS - 1);

  // storage
  logic [7:0]       text_mem [TXT_D];
  logic [COL_W-1:0] len_mem  [LINES];

  // ring state
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  closed_r, closed_nxt;
  logic [COL_W-1:0]  wcol_r, wcol_nxt;

  // read in flight
  logic              rd_pend_r;
  logic              rd_valid_r, rd_partial_r;
  logic [COL_W-1:0]  rd_wcol_r;
  logic [CMP_W-1:0]  rd_col_r;
  logic [8:0]        rd_cnt_r;
  logic [7:0]        text_q_r;
  logic [COL_W-1:0]  len_q_r;

  // output register
  logic      out_valid_r;
  out_word_t out_word_r;

  logic      out_free, in_fire, put_fire, rd_fire, rd_done;
  in_word_t  iw;

  assign iw       = in_bus.data;
  assign out_free = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !rd_pend_r && out_free;
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign put_fire = in_fire && (iw.command == CMD_PUT);
  assign rd_fire  = in_fire && (iw.command == CMD_READ);
  assign rd_done  = rd_pend_r && out_free;

  // put: next ring state and memory writes
  logic             is_cr, is_lf, txt_we, len_we;
  logic [COL_W-1:0] wcol_inc, len_wdata;
  logic [SW1-1:0]   head_inc;
  logic             close_line;

  always_comb begin
    is_cr    = (iw.char_in == CH_CR);
    is_lf    = (iw.char_in == CH_LF);
    wcol_inc = wcol_r + COL_W'(1);
    head_inc = SW1'(head_r) + SW1'(1);
    txt_we   = put_fire && !is_cr && !is_lf;
    close_line = put_fire && (is_lf || (txt_we && (wcol_inc >= COL_MAX)));
    len_we    = close_line;
    len_wdata = is_lf ? wcol_r : wcol_inc;
    head_nxt   = head_r;
    closed_nxt = closed_r;
    wcol_nxt   = wcol_r;
    if (close_line) begin
      head_nxt   = (head_inc == LINES_S) ? '0 : head_inc[SLOT_W-1:0];
      closed_nxt = (closed_r < LINES_C) ? closed_r + CNT_W'(1) : closed_r;
      wcol_nxt   = '0;
    end else if (txt_we) begin
      wcol_nxt = wcol_inc;
    end
  end

  // visible count now and after a put
  logic [CNT_W-1:0] vis_now, vis_nxt;

  always_comb begin
    vis_now = (closed_r < LINES_C) ? closed_r + CNT_W'(wcol_r != '0) : LINES_C;
    vis_nxt = (closed_nxt < LINES_C) ? closed_nxt + CNT_W'(wcol_nxt != '0) : LINES_C;
  end

  // read: logical line to physical slot
  logic             rd_valid, rd_partial, full;
  logic [SW1-1:0]   idx_s, base_raw, base, sum_raw;
  logic [SLOT_W-1:0] rd_slot;

  always_comb begin
    rd_valid   = IDX_W'(iw.line_index) < IDX_W'(vis_now);
    rd_partial = (wcol_r != '0) && (IDX_W'(iw.line_index) == IDX_W'(vis_now) - IDX_W'(1));
    full       = (closed_r >= LINES_C);
    idx_s      = SW1'(iw.line_index);
    base_raw   = SW1'(head_r) + LINES_S - SW1'(closed_r);
    if (full) begin
      base = SW1'(head_r);
    end else if (base_raw >= LINES_S) begin
      base = base_raw - LINES_S;
    end else begin
      base = base_raw;
    end
    sum_raw = base + idx_s + ((full && (wcol_r != '0)) ? SW1'(1) : SW1'(0));
    if (rd_partial) begin
      rd_slot = head_r;
    end else if (sum_raw >= LINES_S) begin
      rd_slot = SLOT_W'(sum_raw - LINES_S);
    end else begin
      rd_slot = sum_raw[SLOT_W-1:0];
    end
  end

  // text memory: write on put, read on read command
  always_ff @(posedge clk) begin
    if (txt_we) begin
      text_mem[{head_r, wcol_r}] <= iw.char_in;
    end
    if (rd_fire) begin
      text_q_r <= text_mem[{rd_slot, COL_W'(iw.column)}];
    end
  end

  // length memory
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[head_r] <= len_wdata;
    end
    if (rd_fire) begin
      len_q_r <= len_mem[rd_slot];
    end
  end

  // read completion
  logic [COL_W-1:0] rd_len;
  logic             rd_hit;
  out_word_t        rd_word, put_word;

  always_comb begin
    rd_len = rd_partial_r ? rd_wcol_r : len_q_r;
    rd_hit = rd_valid_r && (rd_col_r < CMP_W'(rd_len));
    rd_word.read_char  = rd_hit ? text_q_r : 8'h00;
    rd_word.line_valid = rd_valid_r;
    rd_word.line_count = rd_cnt_r;
    put_word.read_char  = 8'h00;
    put_word.line_valid = 1'b0;
    put_word.line_count = 9'(vis_nxt);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      closed_r    <= '0;
      wcol_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      closed_r <= closed_nxt;
      wcol_r   <= wcol_nxt;
      if (rd_fire) begin
        rd_pend_r <= 1'b1;
      end else if (rd_done) begin
        rd_pend_r <= 1'b0;
      end
      if (put_fire || rd_done) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rd_fire) begin
      rd_valid_r   <= rd_valid;
      rd_partial_r <= rd_partial;
      rd_wcol_r    <= wcol_r;
      rd_col_r     <= CMP_W'(iw.column);
      rd_cnt_r     <= 9'(vis_now);
    end
    if (put_fire) begin
      out_word_r <= put_word;
    end else if (rd_done) begin
      out_word_r <= rd_word;
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_word_r;

  // checks
  `LRLB_ASSERT(a_read_pends, rd_fire |=> rd_pend_r, "read word did not enter the read stage")
  `LRLB_ASSERT(a_wcol_range, wcol_r < COL_MAX, "write column reached the line limit")
  `LRLB_ASSERT(a_closed_sat, closed_r <= LINES_C, "closed line count above ring size")
  `LRLB_ASSERT(a_invalid_zero, (out_valid_r && !out_word_r.line_valid) |-> (out_word_r.read_char == 8'h00), "byte returned for invalid line")
  `LRLB_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid_r && !rd_pend_r), "reset left a word in flight")

endmodule
`default_nettype wire

@@ test/line_ring_log_buffer_test.sv @@
// Self-checking testbench for line_ring_log_buffer: directed and random put/read words.
// Depends on lrlb_pkg, lrlb_in_if, lrlb_out_if and the line_ring_log_buffer RTL.
// A scoreboard class tracks the line ring and checks every result word in order.
`default_nettype none
module line_ring_log_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lrlb_pkg::*;

  localparam int LINES = DEF_LINES;
  localparam int COLS = DEF_COLS;
  localparam int unsigned ITEM_TARGET = 1250;
  localparam int unsigned CYCLE_LIMIT = 300000;

  // Tracks ring contents as words are accepted; holds the answers still owed.
  class line_log_tracker;
    logic [7:0] text_mem [LINES*COLS];
    int unsigned len_mem [LINES];
    int unsigned head;
    int unsigned closed_cnt;
    int unsigned col_pos;
    int unsigned lines_ended;
    int unsigned mismatches;
    out_word_t answers_due [$];

    function new();
      foreach (text_mem[i]) text_mem[i] = 8'h00;
      foreach (len_mem[i]) len_mem[i] = 0;
      head = 0;
      closed_cnt = 0;
      col_pos = 0;
      lines_ended = 0;
      mismatches = 0;
    endfunction

    function int unsigned shown_lines();
      if (closed_cnt < LINES) return (col_pos > 0) ? closed_cnt + 1 : closed_cnt;
      return LINES;
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction

    function void end_line();
      len_mem[head] = col_pos;
      head = (head + 1) % LINES;
      if (closed_cnt < LINES) closed_cnt++;
      col_pos = 0;
      lines_ended++;
    endfunction

    // CR dropped, LF closes, a line holding COLS-1 bytes closes on its own
    function void append(logic [7:0] c);
      if (c == CH_CR) return;
      if (c == CH_LF) begin
        end_line();
        return;
      end
      text_mem[head*COLS + col_pos] = c;
      col_pos++;
      if (col_pos >= COLS - 1) end_line();
    endfunction

    function void take_command(in_word_t w);
      out_word_t ans;
      int unsigned shown;
      int unsigned slot;
      int unsigned len;
      ans = '0;
      if (w.command == CMD_PUT) begin
        append(w.char_in);
      end else begin
        shown = shown_lines();
        if (w.line_index < shown) begin
          ans.line_valid = 1'b1;
          if (col_pos > 0 && w.line_index == shown - 1) begin
            // partial line is always the newest visible one
            slot = head;
            len = col_pos;
          end else begin
            if (closed_cnt >= LINES)
              slot = (head + w.line_index + ((col_pos > 0) ? 1 : 0)) % LINES;
            else
              slot = (head + LINES - closed_cnt + w.line_index) % LINES;
            len = len_mem[slot];
          end
          if (w.column < len) ans.read_char = text_mem[slot*COLS + w.column];
        end
      end
      ans.line_count = 9'(shown_lines());
      answers_due.push_back(ans);
    endfunction

    function void compare(string what, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void match_answer(out_word_t got);
      out_word_t want;
      if (answers_due.size() == 0) begin
        $display("%0t: result word with none expected, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = answers_due.pop_front();
      compare("read_char", 9'(want.read_char), 9'(got.read_char));
      compare("line_valid", 9'(want.line_valid), 9'(got.line_valid));
      compare("line_count", want.line_count, got.line_count);
    endfunction
  endclass

  typedef enum logic [1:0] {RX_OPEN, RX_EVERY_THIRD, RX_COIN, RX_SPARSE} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  lrlb_in_if in_bus ();
  lrlb_out_if out_bus ();

  line_log_tracker tracker = new();
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_tick = 0;
  rx_mode_t rx_mode = RX_OPEN;

  line_ring_log_buffer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("line_ring_log_buffer regression: fail");
      $finish;
    end
  end

  // receiver: stall pattern set by a randomly chosen mode
  initial out_bus.ready = 1'b0;
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 97 == 96) rx_mode <= rx_mode_t'(2'($urandom_range(0, 3)));
    case (rx_mode)
      RX_OPEN:        out_bus.ready <= 1'b1;
      RX_EVERY_THIRD: out_bus.ready <= (rx_tick % 3 == 0);
      RX_COIN:        out_bus.ready <= 1'($urandom_range(0, 1));
      default:        out_bus.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) tracker.match_answer(out_bus.data);
  end

  function automatic in_word_t put_word(logic [7:0] c);
    in_word_t w;
    w.command = CMD_PUT;
    w.char_in = c;
    w.line_index = 8'($urandom_range(0, 255));
    w.column = 7'($urandom_range(0, 127));
    return w;
  endfunction

  function automatic in_word_t read_word(int unsigned idx, int unsigned col);
    in_word_t w;
    w.command = CMD_READ;
    w.char_in = 8'($urandom_range(0, 255));
    w.line_index = 8'(idx);
    w.column = 7'(col);
    return w;
  endfunction

  // line content: mostly plain bytes, now and then a stray CR
  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    if ($urandom_range(0, 19) == 0) return CH_CR;
    do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  // reads lean toward the newest lines and toward both ends of a line
  function automatic in_word_t random_read();
    int unsigned shown;
    int unsigned pick;
    int unsigned idx;
    int unsigned col;
    shown = tracker.shown_lines();
    pick = $urandom_range(0, 9);
    if (shown > 0 && pick < 5)
      idx = shown - 1 - $urandom_range(0, (shown > 4) ? 3 : shown - 1);
    else if (shown > 0 && pick < 8)
      idx = $urandom_range(0, shown - 1);
    else
      idx = $urandom_range(0, 255);
    pick = $urandom_range(0, 9);
    if (pick < 4) col = $urandom_range(0, 7);
    else if (pick < 6) col = $urandom_range(120, 127);
    else col = $urandom_range(0, 127);
    return read_word(idx, col);
  endfunction

  // one word through the input handshake, with burst/gap pacing
  task automatic send_word(input in_word_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk);
          in_bus.valid <= 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.data <= w;
    do @(posedge clk); while (!in_bus.ready);
    tracker.take_command(w);
    if (!(w.command == CMD_PUT && w.char_in == CH_CR)) words_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] bits;
    int unsigned pick;
    bit mid_drained;
    mid_drained = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty ring, dropped CR, extreme bytes, past-end and invalid reads
    send_word(read_word(0, 0));
    send_word(put_word(CH_CR));
    send_word(put_word(8'h00));
    send_word(put_word(8'hFF));
    send_word(put_word(CH_CR));
    send_word(read_word(0, 0));
    send_word(read_word(0, 1));
    send_word(read_word(0, 2));
    send_word(read_word(1, 0));
    send_word(put_word(CH_LF));
    // empty line
    send_word(put_word(CH_LF));
    send_word(read_word(1, 0));
    send_word(read_word(0, 1));
    send_word(read_word(255, 127));
    send_word(put_word(8'h7F));
    send_word(put_word(8'h80));
    send_word(put_word(8'h41));
    send_word(read_word(2, 127));
    send_word(read_word(2, 2));
    send_word(read_word(0, 127));
    send_word(put_word(CH_LF));
    send_word(read_word(2, 0));
    drain_results();

    // random: well-formed lines and read bursts, some noise; run past ring wrap
    while (words_sent < ITEM_TARGET || tracker.lines_ended < LINES + 64) begin
      if (!mid_drained && words_sent >= ITEM_TARGET / 2) begin
        drain_results();
        mid_drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        repeat ($urandom_range(0, 6)) send_word(put_word(text_byte()));
        send_word(put_word(CH_LF));
      end else if (pick < 50) begin
        repeat ($urandom_range(1, 24)) send_word(put_word(CH_LF));
      end else if (pick < 53) begin
        // often long enough to force a close; the rest then spills into the next line
        repeat ($urandom_range(110, 140)) send_word(put_word(text_byte()));
        if ($urandom_range(0, 1) == 0) send_word(put_word(CH_LF));
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 6)) begin
          bits = $urandom;
          send_word(in_word_t'(bits[23:0]));
        end
      end else begin
        repeat ($urandom_range(1, 8)) send_word(random_read());
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("line_ring_log_buffer regression: pass");
    end else begin
      $display("line_ring_log_buffer regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/lrlb_pkg.sv
rtl/core/lrlb_in_if.sv
rtl/core/lrlb_out_if.sv
rtl/core/line_ring_log_buffer.sv
test/line_ring_log_buffer_test.sv
